### hdl/crc8wf_pkg.sv
// Shared constants and the CRC-8 byte update for the word frame checker.
// Depends on nothing; used by crc8_word_frame_checker.

package crc8wf_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

  // Position of the next byte within its word.
  localparam logic [1:0] POS_HIGH = 2'd0;
  localparam logic [1:0] POS_LOW  = 2'd1;
  localparam logic [1:0] POS_CRC  = 2'd2;

  localparam logic [7:0] CRC_START_RESET = 8'hFF;

  // Polynomial 0x31 remainders for each leading nibble.
  localparam logic [7:0] NIB_TAB [16] = '{
    8'h00, 8'h31, 8'h62, 8'h53, 8'hc4, 8'hf5, 8'ha6, 8'h97,
    8'hb9, 8'h88, 8'hdb, 8'hea, 8'h7d, 8'h4c, 8'h1f, 8'h2e
  };

  // One byte through the CRC, high nibble first.
  function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
    logic [3:0] p;
    logic [7:0] r;
    p = c[7:4] ^ b[7:4];
    r = {c[3:0], 4'h0} ^ NIB_TAB[p];
    p = r[7:4] ^ b[3:0];
    r = {r[3:0], 4'h0} ^ NIB_TAB[p];
    return r;
  endfunction

endpackage

### hdl/crc8_word_frame_checker.sv
// Top level of the CRC-8 word frame checker: input register, per-byte CRC
// update and word result register. Depends on crc8wf_pkg.

// Usage
// Bytes of a frame enter on data_byte/frame_end with in_valid/in_ready; each
// third byte of a word closes the word and produces one result on
// word_value/status/frame_good/last_result with out_valid/out_ready. A frame
// that ends part-way through a word produces a single length-error result.
// The user is to write the CRC start value through crc_start_we/crc_start only
// while idle; the block does not enforce this. An accepted byte is held in the
// input register until the result register is free, then its result is stored.
// Throughput: one byte per cycle while the receiver does not stall; the CRC
// update is two nibble table steps between the input and CRC state registers.
// When the receiver stalls, the result register holds its word and the input
// register keeps one more byte; in_ready drops only when both are full.
// Reset (synchronous, rst high) empties both registers, starts a new frame
// at the first byte of a word and sets the start value to 0xFF.
module crc8_word_frame_checker
  import crc8wf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        crc_start_we,
  input  logic [7:0]  crc_start,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] word_value,
  output logic [1:0]  status,
  output logic        frame_good,
  output logic        last_result
);

  logic [7:0] crc_start_reg;

  logic       in_full;
  logic [7:0] byte_q;
  logic       end_q;

  logic [1:0] byte_position, byte_position_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] high_byte, high_byte_next;
  logic [7:0] low_byte, low_byte_next;
  logic       frame_failed, frame_failed_next;

  logic        out_free;
  logic        stage_go;
  logic        res_valid;
  logic [15:0] res_word;
  logic [1:0]  res_status;
  logic        res_good;
  logic        bad;

  assign out_free = !out_valid || out_ready;
  assign stage_go = in_full && out_free;
  assign in_ready = !in_full || out_free;

  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    high_byte_next     = high_byte;
    low_byte_next      = low_byte;
    frame_failed_next  = frame_failed;
    res_valid          = 1'b0;
    res_word           = {high_byte, low_byte};
    res_status         = STATUS_OK;
    bad                = (running_crc != byte_q);
    res_good           = !(frame_failed || bad);
    case (byte_position)
      POS_LOW: begin
        low_byte_next      = byte_q;
        running_crc_next   = crc_byte(running_crc, byte_q);
        byte_position_next = POS_CRC;
      end
      POS_CRC: begin
        frame_failed_next  = frame_failed || bad;
        res_valid          = 1'b1;
        res_status         = bad ? STATUS_CRC_ERR : STATUS_OK;
        byte_position_next = POS_HIGH;
      end
      default: begin
        // The unused fourth position behaves as the first byte of a word.
        high_byte_next     = byte_q;
        running_crc_next   = crc_byte(crc_start_reg, byte_q);
        byte_position_next = POS_LOW;
      end
    endcase
    if (end_q) begin
      if (!res_valid) begin
        res_valid  = 1'b1;
        res_word   = 16'h0000;
        res_status = STATUS_LEN_ERR;
        res_good   = 1'b0;
      end
      byte_position_next = POS_HIGH;
      frame_failed_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_start_reg <= CRC_START_RESET;
    end else if (crc_start_we) begin
      crc_start_reg <= crc_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
      end_q  <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HIGH;
      running_crc   <= CRC_START_RESET;
      high_byte     <= 8'h00;
      low_byte      <= 8'h00;
      frame_failed  <= 1'b0;
    end else if (stage_go) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      high_byte     <= high_byte_next;
      low_byte      <= low_byte_next;
      frame_failed  <= frame_failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      word_value  <= res_word;
      status      <= res_status;
      frame_good  <= res_good;
      last_result <= end_q;
    end
  end

`ifndef ASSERT_OFF
  // A length error always closes the frame with an empty word.
  a_len_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_LEN_ERR) |-> (word_value == 16'h0000 && !frame_good
      && last_result))
    else $error("length error result malformed");

  // A mismatched word can never report the frame as good.
  a_crc_err_not_good: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_CRC_ERR) |-> !frame_good)
    else $error("CRC mismatch reported with frame_good set");

  // The last byte of a frame leaves the checker at the start of a clean frame.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (stage_go && end_q) |=> (byte_position == POS_HIGH && !frame_failed))
    else $error("frame state not cleared after last byte");

  // Byte position never reaches the unused code.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position != 2'd3)
    else $error("byte position out of range");
`endif

endmodule

### test/tb.sv
// Self-checking bench for crc8_word_frame_checker: directed frames from a
// table, then random well-formed, corrupted, truncated and noisy frames.
// Depends on crc8wf_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb
  import crc8wf_pkg::*;
();

  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  st;
    logic        good;
    logic        last;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    b;
    logic          fe;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        crc_start_we;
  logic [7:0]  crc_start;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] word_value;
  logic [1:0]  status;
  logic        frame_good;
  logic        last_result;

  crc8_word_frame_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .crc_start_we (crc_start_we),
    .crc_start    (crc_start),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_value   (word_value),
    .status       (status),
    .frame_good   (frame_good),
    .last_result  (last_result)
  );

  // Shadow of the checker's state, advanced on every accepted byte.
  logic [7:0]    start_q;
  logic [1:0]    word_pos;
  logic [7:0]    crc_q;
  logic [7:0]    high_q;
  logic [7:0]    low_q;
  logic          frame_bad;

  frame_result_t frame_results_due[$];
  int            bytes_taken;
  int            check_failures;
  int            send_idle_pct;
  int            recv_stall_pct;
  logic          row_typed;
  frame_result_t row_want;
  stim_row_t     directed_rows [22];

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bitwise CRC-8, polynomial 0x31, most significant bit first.
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ 8'h31) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic bit predict_frame_byte(input logic [7:0] b, input logic fe,
                                            output frame_result_t r);
    bit has;
    has = 1'b0;
    r = '0;
    case (word_pos)
      POS_LOW: begin
        low_q = b;
        crc_q = crc8_step(crc_q, b);
        word_pos = POS_CRC;
      end
      POS_CRC: begin
        if (crc_q != b) frame_bad = 1'b1;
        r.word = {high_q, low_q};
        r.st = (crc_q != b) ? STATUS_CRC_ERR : STATUS_OK;
        r.good = !frame_bad;
        r.last = fe;
        has = 1'b1;
        word_pos = POS_HIGH;
      end
      default: begin
        high_q = b;
        crc_q = crc8_step(start_q, b);
        word_pos = POS_LOW;
      end
    endcase
    if (fe) begin
      // A frame that stops part-way through a word drops the partial word.
      if (!has) begin
        r = '{16'h0000, STATUS_LEN_ERR, 1'b0, 1'b1};
        has = 1'b1;
      end
      word_pos = POS_HIGH;
      frame_bad = 1'b0;
    end
    return has;
  endfunction

  function automatic stim_row_t plain(input logic [7:0] b, input logic fe);
    return '{b, fe, 1'b0, frame_result_t'('0)};
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input logic fe,
                                          input logic [15:0] w, input logic [1:0] st,
                                          input logic good, input logic last);
    return '{b, fe, 1'b1, '{w, st, good, last}};
  endfunction

  always @(posedge clk) begin : monitor
    frame_result_t predicted;
    frame_result_t want;
    bit            has;
    if (!rst) begin
      if (in_valid && in_ready) begin
        has = predict_frame_byte(data_byte, frame_end, predicted);
        if (row_typed) frame_results_due.push_back(row_want);
        else if (has) frame_results_due.push_back(predicted);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: result with none due: word %h status %0d good %0b last %0b",
                   $time, word_value, status, frame_good, last_result);
          check_failures++;
        end else begin
          want = frame_results_due.pop_front();
          if (word_value !== want.word) begin
            $display("%0t: word_value expected %h, got %h", $time, want.word, word_value);
            check_failures++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %0d, got %0d", $time, want.st, status);
            check_failures++;
          end
          if (frame_good !== want.good) begin
            $display("%0t: frame_good expected %0b, got %0b", $time, want.good, frame_good);
            check_failures++;
          end
          if (last_result !== want.last) begin
            $display("%0t: last_result expected %0b, got %0b",
                     $time, want.last, last_result);
            check_failures++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic fe);
    int target;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    frame_end <= fe;
    target = bytes_taken + 1;
    do @(negedge clk); while (bytes_taken < target);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(negedge clk);
    // A leading byte may still sit in the input register with no result due.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_crc_start(input logic [7:0] v);
    crc_start_we <= 1'b1;
    crc_start <= v;
    @(negedge clk);
    crc_start_we <= 1'b0;
    start_q = v;
  endtask

  task automatic send_random_frame();
    int         kind;
    int         n_words;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] chk;
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(7) == 0);
    end else begin
      n_words = $urandom_range(1, 4);
      for (int w = 0; w < n_words; w++) begin
        hi = 8'($urandom);
        lo = 8'($urandom);
        chk = crc8_step(crc8_step(start_q, hi), lo);
        if ($urandom_range(9) == 0) chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(hi, 1'b0);
        send_byte(lo, 1'b0);
        send_byte(chk, (w == n_words - 1) && kind >= 30);
      end
      // Truncated frames end with one or two stray bytes of a further word.
      if (kind < 30) begin
        if ($urandom_range(1)) begin
          send_byte(8'($urandom), 1'b0);
          send_byte(8'($urandom), 1'b1);
        end else begin
          send_byte(8'($urandom), 1'b1);
        end
      end
    end
  endtask

  initial begin : stimulus
    int         phase_base;
    bit         paused;
    logic [7:0] phase_start [5];
    int         phase_idle [5];
    int         phase_stall [5];
    rst = 1'b1;
    crc_start_we = 1'b0;
    crc_start = 8'h00;
    in_valid = 1'b0;
    data_byte = 8'h00;
    frame_end = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    row_typed = 1'b0;
    row_want = '0;
    bytes_taken = 0;
    check_failures = 0;
    start_q = CRC_START_RESET;
    word_pos = POS_HIGH;
    crc_q = CRC_START_RESET;
    high_q = 8'h00;
    low_q = 8'h00;
    frame_bad = 1'b0;

    directed_rows = '{
      plain(8'hBE, 1'b0), plain(8'hEF, 1'b0),
      typed_row(8'h92, 1'b0, 16'hBEEF, STATUS_OK, 1'b1, 1'b0),
      plain(8'h00, 1'b0), plain(8'h00, 1'b0), plain(8'h00, 1'b1),
      typed_row(8'hFF, 1'b1, 16'h0000, STATUS_LEN_ERR, 1'b0, 1'b1),
      plain(8'hFF, 1'b0),
      typed_row(8'hFF, 1'b1, 16'h0000, STATUS_LEN_ERR, 1'b0, 1'b1),
      plain(8'hBE, 1'b0), plain(8'hEF, 1'b0),
      typed_row(8'h92, 1'b1, 16'hBEEF, STATUS_OK, 1'b1, 1'b1),
      plain(8'hBE, 1'b0), plain(8'hEF, 1'b0),
      typed_row(8'h00, 1'b0, 16'hBEEF, STATUS_CRC_ERR, 1'b0, 1'b0),
      plain(8'h12, 1'b0), plain(8'h34, 1'b0), plain(8'h5E, 1'b0),
      typed_row(8'h55, 1'b1, 16'h0000, STATUS_LEN_ERR, 1'b0, 1'b1),
      plain(8'hA5, 1'b0), plain(8'h5A, 1'b0), plain(8'hFF, 1'b1)
    };
    phase_start = '{8'h00, 8'($urandom), 8'hFF, 8'($urandom), 8'($urandom)};
    phase_idle  = '{0, 66, 0, 27, 0};
    phase_stall = '{0, 0, 66, 27, 0};

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_crc_start(CRC_START_RESET);

    for (int i = 0; i < $size(directed_rows); i++) begin
      row_typed = directed_rows[i].typed;
      row_want = directed_rows[i].want;
      send_byte(directed_rows[i].b, directed_rows[i].fe);
    end
    row_typed = 1'b0;
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_crc_start(phase_start[p]);
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      phase_base = bytes_taken;
      paused = 1'b0;
      while (bytes_taken - phase_base < 200) begin
        send_random_frame();
        if (p == 1 && !paused && bytes_taken - phase_base >= 100) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (check_failures == 0 && frame_results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
